// ===== hdl/htfd_pkg.sv =====
// Package for the humidity/temperature frame decoder.
// Holds the frame byte codes, the result record type, the CRC-8 step and the scaling helpers.
// Depends on nothing; every other file of the block imports it.
package htfd_pkg;

    // Byte positions inside the six-byte sensor frame.
    localparam logic [2:0] POS_T_MSB = 3'd0;
    localparam logic [2:0] POS_T_LSB = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_MSB = 3'd3;
    localparam logic [2:0] POS_H_LSB = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    // CRC-8 settings: polynomial x^8+x^5+x^4+1, preset to all ones.
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Status codes of a result.
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_CRC_FAIL = 1'b1;

    // Scaling constants: value = (SPAN * raw + RAW_HALF) / 65535.
    localparam logic [14:0] T_SPAN   = 15'd17500;
    localparam logic [13:0] H_SPAN   = 14'd10000;
    localparam logic [15:0] T_OFFSET = 16'd4500;
    localparam logic [15:0] RAW_HALF = 16'd32767;

    // Depth of the queue between the frame parser and the scaler.
    localparam int QUEUE_DEPTH = 2;

    // One parsed frame, handed from the front part to the back part.
    typedef struct packed {
        logic        status;
        logic [15:0] temperature_raw;
        logic [15:0] humidity_raw;
    } frame_job_t;

    // Occupancy flags of the queue.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_flags_t;

    // One byte of CRC-8, MSB first, no reflection.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // Rounded division by 65535 of a product below 2^31.
    // With x = 65535*q + r, x + (x >> 16) + 1 lands in [65536*q, 65536*q + 65535].
    function automatic logic [15:0] div_by_65535(input logic [31:0] prod);
        logic [32:0] x;
        logic [32:0] s;
        x = {1'b0, prod} + {17'd0, RAW_HALF};
        s = x + {16'd0, x[32:16]} + 33'd1;
        return s[31:16];
    endfunction

endpackage

// ===== hdl/htfd_front.sv =====
// Front part of the frame decoder: tracks the byte position, runs the CRC-8
// checks and assembles the raw words. Depends on htfd_pkg.
module htfd_front
    import htfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_accept,
    input  logic [7:0] data_byte,
    input  logic       frame_start,
    output logic       job_push,
    output frame_job_t job
);

    logic [2:0]  byte_position_reg, byte_position_next;
    logic [7:0]  crc_running_reg, crc_running_next;
    logic [7:0]  word_high_byte_reg, word_high_byte_next;
    logic [15:0] temperature_raw_reg, temperature_raw_next;
    logic [15:0] humidity_raw_reg, humidity_raw_next;
    logic        crc_failed_reg, crc_failed_next;
    logic [2:0]  pos;
    logic        crc_mismatch;

    // Effective position of this byte: a start flag or an impossible code restarts the frame.
    always_comb
    begin
        pos = frame_start ? POS_T_MSB : byte_position_reg;
        if (pos > POS_H_CRC)
            pos = POS_T_MSB;
    end

    assign crc_mismatch = (crc_running_reg != data_byte);

    // Next state of the parser for one accepted byte.
    always_comb
    begin
        byte_position_next   = byte_position_reg;
        crc_running_next     = crc_running_reg;
        word_high_byte_next  = word_high_byte_reg;
        temperature_raw_next = temperature_raw_reg;
        humidity_raw_next    = humidity_raw_reg;
        crc_failed_next      = crc_failed_reg;
        if (byte_accept)
        begin
            byte_position_next = (pos == POS_H_CRC) ? POS_T_MSB : pos + 3'd1;
            unique case (pos)
                POS_T_MSB:
                begin
                    crc_failed_next     = 1'b0;
                    crc_running_next    = crc8_byte(CRC_INIT, data_byte);
                    word_high_byte_next = data_byte;
                end
                POS_T_LSB:
                begin
                    crc_running_next     = crc8_byte(crc_running_reg, data_byte);
                    temperature_raw_next = {word_high_byte_reg, data_byte};
                end
                POS_H_MSB:
                begin
                    crc_running_next    = crc8_byte(CRC_INIT, data_byte);
                    word_high_byte_next = data_byte;
                end
                POS_H_LSB:
                begin
                    crc_running_next  = crc8_byte(crc_running_reg, data_byte);
                    humidity_raw_next = {word_high_byte_reg, data_byte};
                end
                default:
                begin
                    // Both CRC bytes: compare and preset for the next word.
                    if (crc_mismatch)
                        crc_failed_next = 1'b1;
                    crc_running_next = CRC_INIT;
                end
            endcase
        end
    end

    // The last byte of a frame hands a job to the queue.
    always_comb
    begin
        job_push            = byte_accept && (pos == POS_H_CRC);
        job.status          = (crc_failed_reg || crc_mismatch) ? STATUS_CRC_FAIL : STATUS_OK;
        job.temperature_raw = temperature_raw_reg;
        job.humidity_raw    = humidity_raw_reg;
    end

    // Parser registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg   <= POS_T_MSB;
            crc_running_reg     <= CRC_INIT;
            word_high_byte_reg  <= 8'd0;
            temperature_raw_reg <= 16'd0;
            humidity_raw_reg    <= 16'd0;
            crc_failed_reg      <= 1'b0;
        end
        else
        begin
            byte_position_reg   <= byte_position_next;
            crc_running_reg     <= crc_running_next;
            word_high_byte_reg  <= word_high_byte_next;
            temperature_raw_reg <= temperature_raw_next;
            humidity_raw_reg    <= humidity_raw_next;
            crc_failed_reg      <= crc_failed_next;
        end
    end

endmodule

// ===== hdl/htfd_queue.sv =====
// Short first-word-fall-through queue of parsed frames between front and back.
// Depends on htfd_pkg.
module htfd_queue
    import htfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  frame_job_t   push_job,
    input  logic         pop,
    output frame_job_t   head_job,
    output queue_flags_t flags
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    frame_job_t       entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign flags.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign flags.empty = (count_reg == '0);
    assign do_push     = push && !flags.full;
    assign do_pop      = pop && !flags.empty;
    assign head_job    = entry_reg[rd_ptr_reg];

    // Pointer and count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== hdl/htfd_back.sv =====
// Back part of the frame decoder: scales the raw words in a two-stage pipeline
// (multiply, then rounded divide by 65535) and holds the result. Depends on htfd_pkg.
module htfd_back
    import htfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  frame_job_t   head_job,
    input  queue_flags_t flags,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_ready,
    output logic         out_status,
    output logic [14:0]  out_temperature,
    output logic [13:0]  out_humidity
);

    logic        s1_valid_reg;
    logic        s1_status_reg;
    logic [30:0] s1_prod_t_reg;
    logic [29:0] s1_prod_h_reg;
    logic        s2_valid_reg;
    logic        s2_status_reg;
    logic [14:0] s2_temp_reg;
    logic [13:0] s2_hum_reg;
    logic        s1_ready;
    logic        s2_ready;
    logic [15:0] t_quot;
    logic [15:0] h_quot;
    logic [15:0] t_centi;

    // Each stage moves when the one after it is empty or moving.
    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign pop      = s1_ready && !flags.empty;

    // Second stage arithmetic: rounded divide and temperature offset.
    assign t_quot  = div_by_65535({1'b0, s1_prod_t_reg});
    assign h_quot  = div_by_65535({2'b00, s1_prod_h_reg});
    assign t_centi = t_quot - T_OFFSET;

    // Valid bits of the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= !flags.empty;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    // Payload of the pipeline.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_status_reg <= head_job.status;
            s1_prod_t_reg <= {15'd0, head_job.temperature_raw} * {16'd0, T_SPAN};
            s1_prod_h_reg <= {14'd0, head_job.humidity_raw} * {16'd0, H_SPAN};
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_status_reg <= s1_status_reg;
            s2_temp_reg   <= t_centi[14:0];
            s2_hum_reg    <= h_quot[13:0];
        end
    end

    assign out_valid       = s2_valid_reg;
    assign out_status      = s2_status_reg;
    assign out_temperature = s2_temp_reg;
    assign out_humidity    = s2_hum_reg;

endmodule

// ===== hdl/humidity_temp_frame_decoder_unit.sv =====
// Humidity/temperature frame decoder: takes the six-byte sensor read frame one
// byte per transaction (temperature MSB, LSB, CRC, humidity MSB, LSB, CRC) and
// gives one result per frame with the CRC-8 status and both scaled readings.
// A byte is accepted every cycle while the frame queue has room; the queue only
// fills when the result side stalls. The queue entry, the multiply stage and the
// divide stage are written in that order, each stage waiting while the one after
// it is stalled, and a new frame can enter a stage as soon as the frame before it
// has moved on. tuser on the slave side is the frame-start flag, which restarts
// the byte position. The readings are meaningful only when the status in
// m_axis_tuser is 0.
// Depends on htfd_pkg, htfd_front, htfd_queue and htfd_back.
module humidity_temp_frame_decoder_unit
    import htfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi, [31:29] zero
    output logic        m_axis_tuser    // [0] status
);

    logic         byte_accept;
    logic         job_push;
    frame_job_t   push_job;
    frame_job_t   head_job;
    queue_flags_t flags;
    logic         pop;
    logic [14:0]  temperature_centi;
    logic [13:0]  humidity_centi;

    assign s_axis_tready = !flags.full;
    assign byte_accept   = s_axis_tvalid && s_axis_tready;

    // Frame parser.
    htfd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_accept (byte_accept),
        .data_byte   (s_axis_tdata),
        .frame_start (s_axis_tuser),
        .job_push    (job_push),
        .job         (push_job)
    );

    // Queue of parsed frames.
    htfd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .flags    (flags)
    );

    // Scaling pipeline and output register.
    htfd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_job        (head_job),
        .flags           (flags),
        .pop             (pop),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_status      (m_axis_tuser),
        .out_temperature (temperature_centi),
        .out_humidity    (humidity_centi)
    );

    assign m_axis_tdata = {3'b000, humidity_centi, temperature_centi};

endmodule

// ===== hdl/htfd_checker.sv =====
// Port-level checks for the humidity/temperature frame decoder, with the bind
// that attaches them to the top level. Depends on htfd_pkg and the top level.
module htfd_checker
    import htfd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    logic [2:0] pos_reg;
    logic [2:0] pending_reg;
    logic [2:0] pos;
    logic       frame_done;
    logic       out_taken;

    // Track frames completed at the input and results still owed at the output.
    always_comb
    begin
        pos = s_axis_tuser ? POS_T_MSB : pos_reg;
        if (pos > POS_H_CRC)
            pos = POS_T_MSB;
    end
    assign frame_done = s_axis_tvalid && s_axis_tready && (pos == POS_H_CRC);
    assign out_taken  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= POS_T_MSB;
            pending_reg <= 3'd0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                pos_reg <= (pos == POS_H_CRC) ? POS_T_MSB : pos + 3'd1;
            if (frame_done && !out_taken)
                pending_reg <= pending_reg + 3'd1;
            else if (out_taken && !frame_done)
                pending_reg <= pending_reg - 3'd1;
        end
    end

    // A stalled result keeps its data and status.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // No result is shown without a completed frame behind it.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pending_reg != 3'd0)
        else $error("result without a completed frame");

    // The queue and two stages bound the frames in flight.
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'(QUEUE_DEPTH + 2))
        else $error("too many frames in flight");

    // Humidity stays in range and the padding stays clear.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[28:15] <= 14'd10000 && m_axis_tdata[31:29] == 3'b000)
        else $error("humidity out of range or padding set");

endmodule

bind humidity_temp_frame_decoder_unit htfd_checker u_htfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/htfd_frame_checker.sv =====
// Checker for the humidity/temperature frame decoder: watches both stream channels,
// predicts one reading per complete frame and compares every result transaction.
// Depends on htfd_pkg for the byte positions, status codes and CRC constants.
module htfd_frame_checker
    import htfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] frame_start
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi,
                                        // [31:29] zero
    input  logic        m_axis_tuser,   // [0] status
    output int          pending_readings,
    output int          mismatch_count
);

    // One expected result: status and both scaled readings.
    typedef struct packed {
        logic        status;
        logic [14:0] temp_centi;
        logic [13:0] hum_centi;
    } reading_t;

    reading_t    expected_readings[$];
    int          results_seen;

    // Own copy of the frame parser state.
    logic [2:0]  next_pos;
    logic [7:0]  crc_acc;
    logic [7:0]  msb_hold;
    logic [15:0] temp_word;
    logic [15:0] hum_word;
    logic        frame_bad;

    // CRC-8 over one byte, MSB first.
    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // Rounded scaling of both raw words into hundredths.
    function automatic reading_t scale_frame(input logic bad, input logic [15:0] t_raw,
                                             input logic [15:0] h_raw);
        int unsigned tq;
        int unsigned hq;
        reading_t    r;
        tq = (32'd17500 * {16'd0, t_raw} + 32'd32767) / 32'd65535;
        hq = (32'd10000 * {16'd0, h_raw} + 32'd32767) / 32'd65535;
        r.status     = bad;
        r.temp_centi = 15'(tq - 32'd4500);
        r.hum_centi  = 14'(hq);
        return r;
    endfunction

    // Advance the parser by one accepted byte; the sixth byte yields a reading.
    task automatic absorb_byte(input logic [7:0] b, input logic first);
        logic [2:0] pos;
        pos = first ? POS_T_MSB : next_pos;
        if (pos > POS_H_CRC)
            pos = POS_T_MSB;
        next_pos = pos + 3'd1;
        case (pos)
            POS_T_MSB:
            begin
                frame_bad = STATUS_OK;
                crc_acc   = crc_step(CRC_INIT, b);
                msb_hold  = b;
            end
            POS_T_LSB:
            begin
                crc_acc   = crc_step(crc_acc, b);
                temp_word = {msb_hold, b};
            end
            POS_T_CRC:
            begin
                if (crc_acc != b)
                    frame_bad = STATUS_CRC_FAIL;
                crc_acc = CRC_INIT;
            end
            POS_H_MSB:
            begin
                crc_acc  = crc_step(CRC_INIT, b);
                msb_hold = b;
            end
            POS_H_LSB:
            begin
                crc_acc  = crc_step(crc_acc, b);
                hum_word = {msb_hold, b};
            end
            default:
            begin
                if (crc_acc != b)
                    frame_bad = STATUS_CRC_FAIL;
                crc_acc  = CRC_INIT;
                next_pos = POS_T_MSB;
                expected_readings.push_back(scale_frame(frame_bad, temp_word, hum_word));
            end
        endcase
    endtask

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("result %0d: %s mismatch, got 0x%0h, expected 0x%0h",
                 results_seen, field, got, want);
        mismatch_count++;
    endtask

    // Result transactions are checked before the byte of the same edge is taken,
    // since a frame's result can never leave in the cycle of its last byte.
    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
        begin
            next_pos       = POS_T_MSB;
            crc_acc        = CRC_INIT;
            msb_hold       = '0;
            temp_word      = '0;
            hum_word       = '0;
            frame_bad      = STATUS_OK;
            mismatch_count = 0;
            results_seen   = 0;
            expected_readings.delete();
            pending_readings <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_readings.size() == 0)
                    report_mismatch("unexpected result", m_axis_tdata, '0);
                else
                begin
                    want = expected_readings.pop_front();
                    if (m_axis_tuser !== want.status)
                        report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
                    if (m_axis_tdata[14:0] !== want.temp_centi)
                        report_mismatch("temperature", 32'(m_axis_tdata[14:0]),
                                        32'(want.temp_centi));
                    if (m_axis_tdata[28:15] !== want.hum_centi)
                        report_mismatch("humidity", 32'(m_axis_tdata[28:15]),
                                        32'(want.hum_centi));
                    if (m_axis_tdata[31:29] !== 3'd0)
                        report_mismatch("padding", 32'(m_axis_tdata[31:29]), '0);
                end
                results_seen++;
            end
            if (s_axis_tvalid && s_axis_tready)
                absorb_byte(s_axis_tdata, s_axis_tuser);
            pending_readings <= expected_readings.size();
        end
    end

endmodule

// ===== tb/humidity_temp_frame_decoder_unit_tb.sv =====
// Testbench top for the humidity/temperature frame decoder: drives sensor frames,
// random stalls on both channels and gives the verdict.
// Depends on htfd_pkg, the decoder RTL and htfd_frame_checker.
module humidity_temp_frame_decoder_unit_tb
    import htfd_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 16;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;    // [7:0] data_byte
    logic        s_axis_tuser  = 1'b0;  // [0] frame_start
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [14:0] temperature_centi, [28:15] humidity_centi
    logic        m_axis_tuser;          // [0] status

    int pending_readings;
    int mismatch_count;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int bytes_sent    = 0;
    int quiet_cycles  = 0;

    humidity_temp_frame_decoder_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    htfd_frame_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .s_axis_tuser     (s_axis_tuser),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .m_axis_tuser     (m_axis_tuser),
        .pending_readings (pending_readings),
        .mismatch_count   (mismatch_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver stalls at random according to the current phase.
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog on cycles in which no transaction happens on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("humidity_temp_frame_decoder_unit verification failed");
                $finish;
            end
        end
    end

    // Bit-serial CRC-8 of a two-byte word, used to build well-formed frames.
    function automatic logic [7:0] word_crc(input logic [15:0] word);
        logic [7:0] c;
        logic       fb;
        c = CRC_INIT;
        for (int i = 15; i >= 0; i--)
        begin
            fb = c[7] ^ word[i];
            c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    // Raw sensor word with the range ends drawn often.
    function automatic logic [15:0] pick_raw();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // One byte transaction, with random idle cycles ahead of it.
    task automatic send_byte(input logic [7:0] value, input logic first);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= first;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Full six-byte frame; bit 0 of spoil breaks the temperature CRC, bit 1 the humidity CRC.
    task automatic send_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
                              input logic [1:0] spoil, input logic with_start);
        logic [7:0] t_crc;
        logic [7:0] h_crc;
        t_crc = word_crc(t_raw) ^ (spoil[0] ? 8'($urandom_range(1, 255)) : 8'h00);
        h_crc = word_crc(h_raw) ^ (spoil[1] ? 8'($urandom_range(1, 255)) : 8'h00);
        send_byte(t_raw[15:8], with_start);
        send_byte(t_raw[7:0], 1'b0);
        send_byte(t_crc, 1'b0);
        send_byte(h_raw[15:8], 1'b0);
        send_byte(h_raw[7:0], 1'b0);
        send_byte(h_crc, 1'b0);
    endtask

    // Mostly well-formed frames, plus cut-off frames and loose noise bytes.
    task automatic run_random(input int byte_target);
        int kind;
        int n;
        while (bytes_sent < byte_target)
        begin
            kind = $urandom_range(99);
            if (kind < 80)
                send_frame(pick_raw(), pick_raw(),
                           ($urandom_range(99) < 15) ? 2'($urandom_range(1, 3)) : 2'd0,
                           $urandom_range(99) < 75);
            else if (kind < 90)
            begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    send_byte(8'($urandom), i == 0);
            end
            else
            begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    send_byte(8'($urandom), $urandom_range(3) == 0);
            end
        end
    endtask

    // Hold the sender off until every expected reading has come out.
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_readings != 0);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // First phase: sender idles rarely, receiver mostly.
        send_idle_pct = 15;
        recv_idle_pct = 78;

        // Directed frames: no start flag right after reset, wrap without a start
        // flag, a broken temperature CRC, and a start flag in the middle of a frame
        // followed by a broken humidity CRC.
        send_frame(16'h0000, 16'h0000, 2'b00, 1'b0);
        send_frame(16'hFFFF, 16'hFFFF, 2'b00, 1'b0);
        send_frame(16'h6666, 16'h8000, 2'b01, 1'b1);
        send_byte(8'h12, 1'b1);
        send_byte(8'h34, 1'b0);
        send_frame(16'h1234, 16'h0001, 2'b10, 1'b1);

        run_random(600);
        hold_until_drained();

        // Second phase: the other way round.
        send_idle_pct = 78;
        recv_idle_pct = 15;
        run_random(1150);
        hold_until_drained();

        // Last phase: full rate on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(1700);
        hold_until_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_readings == 0)
            $display("humidity_temp_frame_decoder_unit verification clean");
        else
            $display("humidity_temp_frame_decoder_unit verification failed");
        $finish;
    end

endmodule
